[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/psnt_pkg.sv]
// ----------------------------------------------------------------------------
// psnt_pkg
// Shared types and constants for the peer sequence number table.
// ----------------------------------------------------------------------------
package psnt_pkg;

    localparam int MAX_PEERS = 16;
    localparam int SLOT_W    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int PEER_W    = 16;
    localparam int SEQ_W     = 8;
    localparam int WORD_W    = PEER_W + SEQ_W;

    typedef enum logic [1:0] {
        MODE_ALLOC    = 2'd0,
        MODE_VALIDATE = 2'd1,
        MODE_RESYNC   = 2'd2,
        MODE_FORGET   = 2'd3
    } psnt_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_COMMIT
    } psnt_state_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_out;
        logic             accepted;
        logic             new_entry;
    } psnt_result_t;

    typedef struct packed {
        logic [PEER_W-1:0] peer;
        logic [SEQ_W-1:0]  next;
    } psnt_word_t;

endpackage

[rtl/psnt_ram.sv]
// ----------------------------------------------------------------------------
// psnt_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module psnt_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/psnt_out_stage.sv]
// ----------------------------------------------------------------------------
// psnt_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module psnt_out_stage import psnt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  psnt_result_t       result,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SEQ_W-1:0]   seq_out,
    output logic               accepted,
    output logic               new_entry
);

    logic         valid_reg;
    logic         valid_next;
    psnt_result_t data_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign seq_out   = data_reg.seq_out;
    assign accepted  = data_reg.accepted;
    assign new_entry = data_reg.new_entry;

endmodule

[rtl/peer_sequence_number_table_core.sv]
// ----------------------------------------------------------------------------
// peer_sequence_number_table_core
// Fully associative peer id -> next sequence number table, round-robin
// replacement, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request beat: mode, peer_id,
//   seq_in. Output channel (out_valid/out_ready) returns exactly one result
//   beat per request: seq_out, accepted, new_entry.
//   Forget-all skips the lookup and goes straight to its commit step; any
//   other request walks the entry RAM slot by slot from slot 0 until a hit,
//   or through every slot on a miss, each slot in two steps (address issue,
//   then compare on the registered read data). in_ready is high only while
//   no request is in progress, so a new request is taken only once the last
//   one has been committed to the output register.
//   Peer ids and counters live in a single-port RAM; occupancy bits and the
//   victim pointer live in flip-flops. The RAM is not cleared: a slot is
//   only compared once its occupancy bit says it has been written.
//   Reset (rst_n low, async) clears all occupancy bits, the victim pointer
//   and out_valid; the block is ready in the first cycle after.
//   Receiver stall: the finished result sits in the output register; the
//   next request may be accepted and looked up meanwhile, and waits in its
//   commit step until the output register frees, so no beat is lost.
// ----------------------------------------------------------------------------
module peer_sequence_number_table_core import psnt_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [PEER_W-1:0]  peer_id,
    input  logic [SEQ_W-1:0]   seq_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SEQ_W-1:0]   seq_out,
    output logic               accepted,
    output logic               new_entry
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_PEERS - 1);

    // Control state
    psnt_state_t          state_reg, state_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic                 free_found_reg, free_found_next;
    logic [SLOT_W-1:0]    victim_reg, victim_next;
    logic [MAX_PEERS-1:0] used_reg, used_next;

    // Request payload and lookup outcome
    psnt_mode_t           mode_reg, mode_next;
    logic [PEER_W-1:0]    peer_reg, peer_next;
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic [SLOT_W-1:0]    free_slot_reg, free_slot_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [SEQ_W-1:0]     cnt_reg, cnt_next;
    logic                 fresh_reg, fresh_next;

    // RAM port
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_addr;
    psnt_word_t           ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    psnt_word_t           rd_word;

    // Output stage
    logic                 out_load;
    logic                 out_space;
    psnt_result_t         result;

    logic                 slot_hit;
    logic                 free_here;
    logic [SEQ_W-1:0]     cnt_new;

    assign rd_word   = psnt_word_t'(ram_rdata);
    assign slot_hit  = used_reg[idx_reg] && (rd_word.peer == peer_reg);
    assign free_here = !used_reg[idx_reg];

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        victim_next     = victim_reg;
        used_next       = used_reg;
        mode_next       = mode_reg;
        peer_next       = peer_reg;
        seq_next        = seq_reg;
        free_slot_next  = free_slot_reg;
        slot_next       = slot_reg;
        cnt_next        = cnt_reg;
        fresh_next      = fresh_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;
        ram_wdata       = '{peer: peer_reg, next: cnt_reg};
        out_load        = 1'b0;
        result          = '{seq_out: '0, accepted: 1'b1, new_entry: 1'b0};
        cnt_new         = cnt_reg;

        // Result of the committed request
        unique case (mode_reg)
            MODE_ALLOC:
            begin
                result.seq_out = cnt_reg;
                cnt_new        = cnt_reg + SEQ_W'(1);
            end
            MODE_VALIDATE:
            begin
                if (fresh_reg || (seq_reg == cnt_reg))
                begin
                    result.seq_out = seq_reg;
                    cnt_new        = seq_reg + SEQ_W'(1);
                end
                else
                begin
                    result.seq_out  = cnt_reg;
                    result.accepted = 1'b0;
                end
            end
            MODE_RESYNC:
            begin
                result.seq_out = seq_reg;
                cnt_new        = seq_reg;
            end
            MODE_FORGET:
            begin
                result.seq_out = '0;
            end
            default:
            begin
                result.seq_out = '0;
            end
        endcase
        if (mode_reg != MODE_FORGET)
        begin
            result.new_entry = fresh_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next       = psnt_mode_t'(mode);
                    peer_next       = peer_id;
                    seq_next        = seq_in;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    fresh_next      = 1'b0;
                    state_next      = (psnt_mode_t'(mode) == MODE_FORGET) ? ST_COMMIT
                                                                          : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!free_found_reg && free_here)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = idx_reg;
                end
                if (slot_hit)
                begin
                    slot_next  = idx_reg;
                    cnt_next   = rd_word.next;
                    fresh_next = 1'b0;
                    state_next = ST_COMMIT;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    // Miss: lowest free slot, else the round-robin victim
                    cnt_next   = '0;
                    fresh_next = 1'b1;
                    state_next = ST_COMMIT;
                    if (free_found_reg)
                    begin
                        slot_next = free_slot_reg;
                    end
                    else if (free_here)
                    begin
                        slot_next = idx_reg;
                    end
                    else
                    begin
                        slot_next   = victim_reg;
                        victim_next = (victim_reg == LAST_SLOT) ? '0
                                                                : victim_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    idx_next   = idx_reg + SLOT_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_COMMIT:
            begin
                ram_addr = slot_reg;
                if (out_space)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (mode_reg == MODE_FORGET)
                    begin
                        used_next   = '0;
                        victim_next = '0;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        ram_wdata           = '{peer: peer_reg, next: cnt_new};
                        used_next[slot_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            victim_reg     <= '0;
            used_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            free_found_reg <= free_found_next;
            victim_reg     <= victim_next;
            used_reg       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        peer_reg      <= peer_next;
        seq_reg       <= seq_next;
        free_slot_reg <= free_slot_next;
        slot_reg      <= slot_next;
        cnt_reg       <= cnt_next;
        fresh_reg     <= fresh_next;
    end

    psnt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_PEERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (WORD_W'(ram_wdata)),
        .rdata (ram_rdata)
    );

    psnt_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .result    (result),
        .space     (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .seq_out   (seq_out),
        .accepted  (accepted),
        .new_entry (new_entry)
    );

endmodule

[rtl/psnt_checker.sv]
// ----------------------------------------------------------------------------
// psnt_checker
// Port-level checks for the peer sequence number table, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psnt_checker import psnt_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        mode,
    input logic [PEER_W-1:0] peer_id,
    input logic [SEQ_W-1:0]  seq_in,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SEQ_W-1:0]  seq_out,
    input logic              accepted,
    input logic              new_entry
);

    // A stalled result beat stays up
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

    // A stalled result beat keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(seq_out) && $stable(accepted) && $stable(new_entry), "result payload changed while stalled")

    // One request at a time: no second beat taken right after an accept
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while another in progress")

    // A fresh entry never rejects a validate
    `ASSERT_ALWAYS(a_fresh_accepts, clk, rst_n, !out_valid || accepted || !new_entry, "new entry reported with a rejection")

endmodule

bind peer_sequence_number_table_core psnt_checker u_psnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .peer_id   (peer_id),
    .seq_in    (seq_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .seq_out   (seq_out),
    .accepted  (accepted),
    .new_entry (new_entry)
);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for peer_sequence_number_table_core. Directed beats
// cover wrap-around, match and mismatch on validate, resync, forget-all and
// round-robin eviction. Random beats then run against a small scoreboard
// that keeps its own copy of the slot table. Both channels idle at varying
// rates, and one long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import psnt_pkg::*;

    // Timing and run-length figures.
    localparam int RANDOM_PER_PHASE = 280;
    localparam int POOL_REFRESH     = 70;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_CYCLES     = 2 * MAX_PEERS + 10;   // a lookup plus slack
    localparam int CYCLE_LIMIT      = 400_000;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the slot table and queues one expected result per
    // accepted request beat.
    // ------------------------------------------------------------------------
    class seq_table_scoreboard;
        bit                slot_taken [MAX_PEERS];
        logic [PEER_W-1:0] slot_owner [MAX_PEERS];
        logic [SEQ_W-1:0]  slot_count [MAX_PEERS];
        int unsigned       rr_victim;
        psnt_result_t      expected_results [$];
        int unsigned       failures;

        function new();
            foreach (slot_taken[i])
                slot_taken[i] = 1'b0;
            rr_victim = 0;
            failures  = 0;
        endfunction

        // Hit, else lowest free slot, else the round-robin victim.
        function int find_or_claim(input logic [PEER_W-1:0] peer, output bit fresh);
            int slot;
            fresh = 1'b0;
            for (int i = 0; i < MAX_PEERS; i++)
                if (slot_taken[i] && slot_owner[i] == peer)
                    return i;
            fresh = 1'b1;
            for (int i = 0; i < MAX_PEERS; i++)
                if (!slot_taken[i])
                begin
                    slot_taken[i] = 1'b1;
                    slot_owner[i] = peer;
                    slot_count[i] = '0;
                    return i;
                end
            slot = rr_victim;
            rr_victim = (rr_victim + 1) % MAX_PEERS;
            slot_owner[slot] = peer;
            slot_count[slot] = '0;
            return slot;
        endfunction

        // Current counter of a resident peer, for building matching validates.
        function bit known_count(input logic [PEER_W-1:0] peer,
                                 output logic [SEQ_W-1:0] cnt);
            cnt = '0;
            for (int i = 0; i < MAX_PEERS; i++)
                if (slot_taken[i] && slot_owner[i] == peer)
                begin
                    cnt = slot_count[i];
                    return 1'b1;
                end
            return 1'b0;
        endfunction

        function void note_request(input psnt_mode_t m,
                                   input logic [PEER_W-1:0] peer,
                                   input logic [SEQ_W-1:0] seq);
            psnt_result_t r;
            bit           fresh;
            int           slot;
            r.seq_out   = '0;
            r.accepted  = 1'b1;
            r.new_entry = 1'b0;
            if (m == MODE_FORGET)
            begin
                foreach (slot_taken[i])
                    slot_taken[i] = 1'b0;
                rr_victim = 0;
            end
            else
            begin
                slot = find_or_claim(peer, fresh);
                r.new_entry = fresh;
                case (m)
                    MODE_ALLOC:
                    begin
                        r.seq_out = slot_count[slot];
                        slot_count[slot] = slot_count[slot] + 8'd1;
                    end
                    MODE_VALIDATE:
                    begin
                        if (fresh || seq == slot_count[slot])
                        begin
                            r.seq_out = seq;
                            slot_count[slot] = seq + 8'd1;
                        end
                        else
                        begin
                            r.accepted = 1'b0;
                            r.seq_out  = slot_count[slot];
                        end
                    end
                    default:
                    begin
                        slot_count[slot] = seq;
                        r.seq_out = seq;
                    end
                endcase
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(input logic [SEQ_W-1:0] s, input logic a,
                                   input logic n);
            psnt_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing outstanding: seq_out=%0d accepted=%0b new_entry=%0b",
                       s, a, n);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (s !== want.seq_out)
            begin
                $error("seq_out: expected %0d, got %0d", want.seq_out, s);
                failures++;
            end
            if (a !== want.accepted)
            begin
                $error("accepted: expected %0b, got %0b", want.accepted, a);
                failures++;
            end
            if (n !== want.new_entry)
            begin
                $error("new_entry: expected %0b, got %0b", want.new_entry, n);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its signals.
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        mode;
    logic [PEER_W-1:0] peer_id;
    logic [SEQ_W-1:0]  seq_in;
    logic              out_valid;
    logic              out_ready;
    logic [SEQ_W-1:0]  seq_out;
    logic              accepted;
    logic              new_entry;

    peer_sequence_number_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .peer_id   (peer_id),
        .seq_in    (seq_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .seq_out   (seq_out),
        .accepted  (accepted),
        .new_entry (new_entry)
    );

    always #5 clk = ~clk;

    seq_table_scoreboard sb;

    // Idling rates in percent; the main sequence changes them per phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long receiver hold-off: the main sequence raises the request, the
    // receiver process counts the stretch out itself.
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;

    logic [PEER_W-1:0] peer_pool [32];

    // ------------------------------------------------------------------------
    // Receiver: one decision per edge on out_ready.
    // ------------------------------------------------------------------------
    initial out_ready = 1'b0;

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor: values seen here are those that stood at the edge.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(seq_out, accepted, new_entry);

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** peer_sequence_number_table_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. A gap drops valid first; otherwise the next beat
    // follows straight on, so valid is written once per edge.
    // ------------------------------------------------------------------------
    task automatic send_beat(input psnt_mode_t m, input logic [PEER_W-1:0] p,
                             input logic [SEQ_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        peer_id  <= p;
        seq_in   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        // Accepted at this edge: predict now, before the next beat is built.
        sb.note_request(m, p, s);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        psnt_mode_t        m;
        logic [PEER_W-1:0] p;
        logic [SEQ_W-1:0]  s;
        logic [SEQ_W-1:0]  cnt;
        int unsigned       roll;
        int unsigned       pool_size;

        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        mode     = MODE_ALLOC;
        peer_id  = '0;
        seq_in   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed part -------------------------------------------------
        send_beat(MODE_ALLOC,    16'h0000, 8'h00);  // first peer, counter from zero
        send_beat(MODE_ALLOC,    16'hFFFF, 8'hFF);  // top id
        send_beat(MODE_VALIDATE, 16'hFFFF, 8'h01);  // match
        send_beat(MODE_VALIDATE, 16'hFFFF, 8'h55);  // mismatch, reports expected
        send_beat(MODE_VALIDATE, 16'h1234, 8'hFF);  // unseen peer taken as is, wraps
        send_beat(MODE_ALLOC,    16'h1234, 8'hAA);  // counter wrapped to zero
        send_beat(MODE_RESYNC,   16'hA5A5, 8'hFF);  // resync inserts on a miss
        send_beat(MODE_ALLOC,    16'hA5A5, 8'h00);  // 0xFF then wraps
        send_beat(MODE_FORGET,   16'h5A5A, 8'h7E);  // clears the table
        // Fill every slot, then two misses evict slots 0 and 1 in turn;
        // the second one brings back the peer that was just evicted.
        for (int i = 0; i <= MAX_PEERS; i++)
            send_beat(MODE_ALLOC, 16'h0100 + 16'(i), 8'(i));
        send_beat(MODE_VALIDATE, 16'h0100, 8'h80);

        // --- Random part ---------------------------------------------------
        // Phases: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 18 : 0;
            recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 18 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Fresh peer pool now and then; sizes either side of the
                // table depth so that hits, misses and evictions all occur.
                if (n % POOL_REFRESH == 0)
                begin
                    case ((n / POOL_REFRESH + ph) % 4)
                        0:       pool_size = 6;
                        1:       pool_size = 14;
                        2:       pool_size = 20;
                        default: pool_size = 32;
                    endcase
                    foreach (peer_pool[i])
                        peer_pool[i] = 16'($urandom_range(0, 65535));
                end
                if (ph == 0 && n == 40)
                    hold_request = 1'b1;

                roll = $urandom_range(99);
                if (roll < 35)
                    m = MODE_ALLOC;
                else if (roll < 70)
                    m = MODE_VALIDATE;
                else if (roll < 98)
                    m = MODE_RESYNC;
                else
                    m = MODE_FORGET;
                if ($urandom_range(99) < 6)
                    p = 16'($urandom_range(0, 65535));
                else
                    p = peer_pool[$urandom_range(0, pool_size - 1)];
                s = 8'($urandom_range(0, 255));
                // Most validates of resident peers carry the right number.
                if (m == MODE_VALIDATE && sb.known_count(p, cnt) && $urandom_range(99) < 70)
                    s = cnt;
                send_beat(m, p, s);
            end
        end

        // --- Drain ---------------------------------------------------------
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("** peer_sequence_number_table_core: PASSED **");
        else
            $display("** peer_sequence_number_table_core: FAILED **");
        $finish;
    end

endmodule

[peer_sequence_number_table_core.f]
+incdir+rtl
rtl/psnt_pkg.sv
rtl/psnt_ram.sv
rtl/psnt_out_stage.sv
rtl/peer_sequence_number_table_core.sv
rtl/psnt_checker.sv
verif/testbench.sv
